[rtl/tanh_q24_interp_lookup_unit_assert.svh]
// Assertion macros for the tanh lookup unit.
// Used by the top level only; needs no package.
`ifndef TANH_Q24_INTERP_LOOKUP_UNIT_ASSERT_SVH
`define TANH_Q24_INTERP_LOOKUP_UNIT_ASSERT_SVH

// Same-cycle implication, skipped while reset is high
`define TANHQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, skipped while reset is high
`define TANHQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/tanhq_pkg.sv]
// Shared constants and types for the tanh lookup unit.
// No dependencies.
package tanhq_pkg;

  // default table sizes (log2 of entries)
  localparam int EXP2_LOG_DEF = 10;
  localparam int TANH_LOG_DEF = 10;

  // register stages from input to output register
  localparam int NUM_STAGES = 7;

  // magnitude thresholds, Q8.24
  localparam logic [31:0] SAT_LIMIT = 32'd17 << 23;
  localparam logic [31:0] EXP_LIMIT = 32'd4 << 24;

  // 2*log2(e) in Q24, applied to the magnitude and negated later
  localparam logic [25:0] TWO_LOG2E_Q24 = 26'd48408812;

  // 1.0 in Q24, truncated to the output width
  localparam logic [25:0] ONE_Q24 = 26'd1 << 24;

  // which formula the sample takes
  typedef enum logic [1:0] {
    CLS_TANH,
    CLS_EXP,
    CLS_SAT
  } cls_t;

  // side information that travels down the pipe with each word
  typedef struct packed {
    logic neg;
    cls_t cls;
  } tag_t;

endpackage

[rtl/tanhq_front.sv]
// Front end of the tanh pipe: sign fold, range split, exponent product
// and table address decode (stages 1 to 3). Depends on tanhq_pkg.
module tanhq_front #(
  parameter int EXP2_LOG_ENTRIES = tanhq_pkg::EXP2_LOG_DEF,
  parameter int TANH_LOG_ENTRIES = tanhq_pkg::TANH_LOG_DEF
) (
  input  logic                                 clk,
  input  logic [tanhq_pkg::NUM_STAGES-1:0]     ld,
  input  logic [31:0]                          x_in,
  output logic [EXP2_LOG_ENTRIES-1:0]          e_idx,
  output logic [24-EXP2_LOG_ENTRIES-1:0]       e_low,
  output logic [4:0]                           e_shift,
  output logic                                 e_zero,
  output logic [TANH_LOG_ENTRIES-1:0]          t_idx,
  output logic [26-TANH_LOG_ENTRIES-1:0]       t_low,
  output tanhq_pkg::tag_t                      tag
);
  import tanhq_pkg::*;

  localparam int ESH = 24 - EXP2_LOG_ENTRIES;
  localparam int TSH = 26 - TANH_LOG_ENTRIES;

  logic [31:0]                 m_fold;
  cls_t                        cls_in;
  logic [31:0]                 m1;
  tag_t                        tag1;
  logic [52:0]                 p2;
  logic [TANH_LOG_ENTRIES-1:0] t_idx2;
  logic [TSH-1:0]              t_low2;
  tag_t                        tag2;
  logic [53:0]                 p_rnd;
  logic [31:0]                 sx;
  logic signed [9:0]           s_full;

  // stage 1: ones-complement fold and range split
  always_comb begin
    m_fold = x_in ^ {32{x_in[31]}};
    if (m_fold >= SAT_LIMIT) begin
      cls_in = CLS_SAT;
    end else if (m_fold >= EXP_LIMIT) begin
      cls_in = CLS_EXP;
    end else begin
      cls_in = CLS_TANH;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      m1       <= m_fold;
      tag1.neg <= x_in[31];
      tag1.cls <= cls_in;
    end
  end

  // stage 2: exponent product over the full exp2 range (below 8.5, 28 bits);
  // tanh address taken straight from the magnitude
  always_ff @(posedge clk) begin
    if (ld[1]) begin
      p2     <= 53'(TWO_LOG2E_Q24) * 53'(m1[27:0]);
      t_idx2 <= m1[25:TSH];
      t_low2 <= m1[TSH-1:0];
      tag2   <= tag1;
    end
  end

  // stage 3: round product up, negate, split into integer and fraction
  always_comb begin
    p_rnd  = {1'b0, p2} + 54'h0FF_FFFF;
    sx     = 32'd0 - {2'b00, p_rnd[53:24]};
    s_full = 10'sd6 - $signed({{2{sx[31]}}, sx[31:24]});
  end

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      e_idx   <= sx[23:ESH];
      e_low   <= sx[ESH-1:0];
      e_shift <= s_full[9] ? 5'd0 : s_full[4:0];
      e_zero  <= !s_full[9] && (s_full[8:5] != 4'd0);
      t_idx   <= t_idx2;
      t_low   <= t_low2;
      tag     <= tag2;
    end
  end

endmodule

[rtl/tanhq_rom.sv]
// Constant tables of the tanh unit (2^frac and tanh on [0,4)), built at
// elaboration, with registered reads (stage 4). Depends on tanhq_pkg.
module tanhq_rom #(
  parameter int EXP2_LOG_ENTRIES = tanhq_pkg::EXP2_LOG_DEF,
  parameter int TANH_LOG_ENTRIES = tanhq_pkg::TANH_LOG_DEF
) (
  input  logic                                 clk,
  input  logic [tanhq_pkg::NUM_STAGES-1:0]     ld,
  input  logic [EXP2_LOG_ENTRIES-1:0]          e_idx,
  input  logic [24-EXP2_LOG_ENTRIES-1:0]       e_low,
  input  logic [4:0]                           e_shift,
  input  logic                                 e_zero,
  input  logic [TANH_LOG_ENTRIES-1:0]          t_idx,
  input  logic [26-TANH_LOG_ENTRIES-1:0]       t_low,
  input  tanhq_pkg::tag_t                      tag,
  output logic [31:0]                          e_delta,
  output logic [31:0]                          e_val,
  output logic [24-EXP2_LOG_ENTRIES-1:0]       e_low_q,
  output logic [4:0]                           e_shift_q,
  output logic                                 e_zero_q,
  output logic signed [24:0]                   t_delta,
  output logic signed [24:0]                   t_val,
  output logic [26-TANH_LOG_ENTRIES-1:0]       t_low_q,
  output tanhq_pkg::tag_t                      tag_q
);
  import tanhq_pkg::*;

  localparam int EXP2_N = 1 << EXP2_LOG_ENTRIES;
  localparam int TANH_N = 1 << TANH_LOG_ENTRIES;
  localparam logic [63:0] Q60_ONE  = 64'd1 << 60;
  localparam logic [31:0] EXP2_TOP = 32'd1 << 31;

  // each entry is {delta, value}
  typedef logic [EXP2_N-1:0][63:0] exp2_tab_t;
  typedef logic [TANH_N-1:0][49:0] tanh_tab_t;

  // (a*b) >> s, low 64 bits
  function automatic logic [63:0] mul_shr(input logic [63:0] a, input logic [63:0] b,
                                          input int s);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return 64'(p >> s);
  endfunction

  // floor(sqrt(v * 2^62)), bit by bit
  function automatic logic [63:0] sqrt_q62(input logic [63:0] v);
    logic [127:0] t;
    logic [63:0]  s;
    logic [63:0]  c;
    t = {64'd0, v} << 62;
    s = '0;
    for (int b = 62; b >= 0; b--) begin
      c = s | (64'd1 << b);
      if (({64'd0, c} * {64'd0, c}) <= t) begin
        s = c;
      end
    end
    return s;
  endfunction

  // 1 - y^2 in Q60, argument clipped to 1.0
  function automatic logic [63:0] dtanh_q60(input logic [63:0] v);
    logic [63:0] w;
    w = (v > Q60_ONE) ? Q60_ONE : v;
    return Q60_ONE - mul_shr(w, w, 60);
  endfunction

  // 2^(i/N) in Q30 by repeated multiplication with the N-th root of two
  function automatic exp2_tab_t build_exp2();
    exp2_tab_t   tab;
    logic [63:0] inc;
    logic [63:0] y;
    tab = '0;
    inc = 64'd1 << 63;
    y   = 64'd1 << 62;
    for (int i = 0; i < EXP2_LOG_ENTRIES; i++) begin
      inc = sqrt_q62(inc);
    end
    for (int i = 0; i < EXP2_N; i++) begin
      tab[i][31:0] = 32'((y + (64'd1 << 31)) >> 32);
      y = mul_shr(y, inc, 62);
    end
    for (int i = 0; i < EXP2_N - 1; i++) begin
      tab[i][63:32] = tab[i+1][31:0] - tab[i][31:0];
    end
    tab[EXP2_N-1][63:32] = EXP2_TOP - tab[EXP2_N-1][31:0];
    return tab;
  endfunction

  // tanh on [0,4) from RK4 on y' = 1 - y^2, carried in Q60
  function automatic tanh_tab_t build_tanh();
    tanh_tab_t   tab;
    logic [63:0] y;
    logic [63:0] k1;
    logic [63:0] k2;
    logic [63:0] k3;
    logic [63:0] k4;
    logic [63:0] sum;
    int          lh;
    int          lf;
    tab = '0;
    y   = '0;
    lh  = TANH_LOG_ENTRIES - 1;
    lf  = TANH_LOG_ENTRIES - 2;
    for (int i = 0; i < TANH_N; i++) begin
      tab[i][24:0] = 25'((y + (64'd1 << 35)) >> 36);
      k1  = dtanh_q60(y);
      k2  = dtanh_q60(y + (k1 >> lh));
      k3  = dtanh_q60(y + (k2 >> lh));
      k4  = dtanh_q60(y + (k3 >> lf));
      sum = k1 + k4 + 64'd2 * (k2 + k3);
      y   = y + ((sum / 64'd6) >> lf);
    end
    for (int i = 0; i < TANH_N - 1; i++) begin
      tab[i][49:25] = tab[i+1][24:0] - tab[i][24:0];
    end
    tab[TANH_N-1][49:25] = 25'((y + (64'd1 << 35)) >> 36) - tab[TANH_N-1][24:0];
    return tab;
  endfunction

  localparam exp2_tab_t EXP2_TAB = build_exp2();
  localparam tanh_tab_t TANH_TAB = build_tanh();

  logic [63:0] e_word;
  logic [49:0] t_word;

  // stage 4: registered table reads, side fields follow
  always_ff @(posedge clk) begin
    if (ld[3]) begin
      e_word    <= EXP2_TAB[e_idx];
      t_word    <= TANH_TAB[t_idx];
      e_low_q   <= e_low;
      e_shift_q <= e_shift;
      e_zero_q  <= e_zero;
      t_low_q   <= t_low;
      tag_q     <= tag;
    end
  end

  assign e_delta = e_word[63:32];
  assign e_val   = e_word[31:0];
  assign t_delta = $signed(t_word[49:25]);
  assign t_val   = $signed(t_word[24:0]);

endmodule

[rtl/tanhq_interp.sv]
// Back end of the tanh pipe: interpolation products, sums, exponent shift
// and sign restore into the output register (stages 5 to 7). Depends on tanhq_pkg.
module tanhq_interp #(
  parameter int EXP2_LOG_ENTRIES = tanhq_pkg::EXP2_LOG_DEF,
  parameter int TANH_LOG_ENTRIES = tanhq_pkg::TANH_LOG_DEF
) (
  input  logic                                 clk,
  input  logic [tanhq_pkg::NUM_STAGES-1:0]     ld,
  input  logic [31:0]                          e_delta,
  input  logic [31:0]                          e_val,
  input  logic [24-EXP2_LOG_ENTRIES-1:0]       e_low,
  input  logic [4:0]                           e_shift,
  input  logic                                 e_zero,
  input  logic signed [24:0]                   t_delta,
  input  logic signed [24:0]                   t_val,
  input  logic [26-TANH_LOG_ENTRIES-1:0]       t_low,
  input  tanhq_pkg::tag_t                      tag,
  output logic [25:0]                          y_out
);
  import tanhq_pkg::*;

  localparam int ESH = 24 - EXP2_LOG_ENTRIES;
  localparam int TSH = 26 - TANH_LOG_ENTRIES;

  logic [31+ESH:0]        e_prod5;
  logic [31:0]            e_val5;
  logic signed [25+TSH:0] t_prod5;
  logic signed [24:0]     t_val5;
  logic [4:0]             e_shift5;
  logic                   e_zero5;
  tag_t                   tag5;
  logic signed [25+TSH:0] t_q;
  logic [31:0]            yv6;
  logic [25:0]            t_r6;
  logic [4:0]             e_shift6;
  logic                   e_zero6;
  tag_t                   tag6;
  logic [31:0]            e_shr;
  logic [25:0]            e_r;
  logic [25:0]            r;

  // stage 5: slope times fraction for both tables
  always_ff @(posedge clk) begin
    if (ld[4]) begin
      e_prod5  <= (32+ESH)'(e_delta) * (32+ESH)'(e_low);
      t_prod5  <= (26+TSH)'(t_delta) * (26+TSH)'($signed({1'b0, t_low}));
      e_val5   <= e_val;
      t_val5   <= t_val;
      e_shift5 <= e_shift;
      e_zero5  <= e_zero;
      tag5     <= tag;
    end
  end

  // stage 6: floor the products and add the base values
  assign t_q = t_prod5 >>> TSH;

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      yv6      <= e_val5 + e_prod5[31+ESH:ESH];
      t_r6     <= {t_val5[24], t_val5} + t_q[25:0];
      e_shift6 <= e_shift5;
      e_zero6  <= e_zero5;
      tag6     <= tag5;
    end
  end

  // stage 7: scale 2^s down, form 1 - 2*2^s, pick the branch, fold sign back
  always_comb begin
    e_shr = e_zero6 ? 32'd0 : (yv6 >> e_shift6);
    e_r   = ONE_Q24 - {e_shr[24:0], 1'b0};
    case (tag6.cls)
      CLS_SAT:  r = ONE_Q24;
      CLS_EXP:  r = e_r;
      CLS_TANH: r = t_r6;
      default:  r = t_r6;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld[6]) begin
      y_out <= r ^ {26{tag6.neg}};
    end
  end

endmodule

[rtl/tanh_q24_interp_lookup_unit.sv]
// Top level of the tanh lookup unit: stream ports, valid chain and stall
// control. Depends on tanhq_pkg, tanhq_front, tanhq_rom, tanhq_interp.
//
//   Channel   Role     Content
//   s_axis    in       x_in, Q8.24 signed sample
//   m_axis    out      y_out, Q24 tanh, negative results ones-complemented
//
// One word per cycle sustained while m_axis_tready is high; seven register stages
// (fold, multiply, decode, table read, products, sums, output) lie between the
// channels. Tables are constants, so no start-up pass is needed; reset clears
// only the valid bits. A stall holds a stage only while its successor is full,
// so bubbles close up behind a blocked output.
`include "tanh_q24_interp_lookup_unit_assert.svh"

module tanh_q24_interp_lookup_unit #(
  parameter int EXP2_LOG_ENTRIES = tanhq_pkg::EXP2_LOG_DEF,
  parameter int TANH_LOG_ENTRIES = tanhq_pkg::TANH_LOG_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] x_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [25:0] y_out, [31:26] zero
);
  import tanhq_pkg::*;

  localparam int ESH = 24 - EXP2_LOG_ENTRIES;
  localparam int TSH = 26 - TANH_LOG_ENTRIES;

  logic [NUM_STAGES-1:0]       v;
  logic [NUM_STAGES-1:0]       ld;
  logic                        in_acc;
  logic                        out_acc;

  logic [EXP2_LOG_ENTRIES-1:0] e_idx;
  logic [ESH-1:0]              e_low;
  logic [4:0]                  e_shift;
  logic                        e_zero;
  logic [TANH_LOG_ENTRIES-1:0] t_idx;
  logic [TSH-1:0]              t_low;
  tag_t                        tag3;

  logic [31:0]                 e_delta;
  logic [31:0]                 e_val;
  logic [ESH-1:0]              e_low4;
  logic [4:0]                  e_shift4;
  logic                        e_zero4;
  logic signed [24:0]          t_delta;
  logic signed [24:0]          t_val;
  logic [TSH-1:0]              t_low4;
  tag_t                        tag4;

  logic [25:0]                 y_out;

  // load enables: a stage takes a new word when empty or when it moves on
  always_comb begin
    ld[NUM_STAGES-1] = !v[NUM_STAGES-1] || m_axis_tready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      ld[k] = !v[k] || ld[k+1];
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (ld[0]) begin
        v[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (ld[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  assign s_axis_tready = ld[0];
  assign m_axis_tvalid = v[NUM_STAGES-1];
  assign m_axis_tdata  = {6'd0, y_out};
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_acc       = m_axis_tvalid && m_axis_tready;

  tanhq_front #(
    .EXP2_LOG_ENTRIES (EXP2_LOG_ENTRIES),
    .TANH_LOG_ENTRIES (TANH_LOG_ENTRIES)
  ) u_front (
    .clk     (clk),
    .ld      (ld),
    .x_in    (s_axis_tdata),
    .e_idx   (e_idx),
    .e_low   (e_low),
    .e_shift (e_shift),
    .e_zero  (e_zero),
    .t_idx   (t_idx),
    .t_low   (t_low),
    .tag     (tag3)
  );

  tanhq_rom #(
    .EXP2_LOG_ENTRIES (EXP2_LOG_ENTRIES),
    .TANH_LOG_ENTRIES (TANH_LOG_ENTRIES)
  ) u_rom (
    .clk       (clk),
    .ld        (ld),
    .e_idx     (e_idx),
    .e_low     (e_low),
    .e_shift   (e_shift),
    .e_zero    (e_zero),
    .t_idx     (t_idx),
    .t_low     (t_low),
    .tag       (tag3),
    .e_delta   (e_delta),
    .e_val     (e_val),
    .e_low_q   (e_low4),
    .e_shift_q (e_shift4),
    .e_zero_q  (e_zero4),
    .t_delta   (t_delta),
    .t_val     (t_val),
    .t_low_q   (t_low4),
    .tag_q     (tag4)
  );

  tanhq_interp #(
    .EXP2_LOG_ENTRIES (EXP2_LOG_ENTRIES),
    .TANH_LOG_ENTRIES (TANH_LOG_ENTRIES)
  ) u_interp (
    .clk     (clk),
    .ld      (ld),
    .e_delta (e_delta),
    .e_val   (e_val),
    .e_low   (e_low4),
    .e_shift (e_shift4),
    .e_zero  (e_zero4),
    .t_delta (t_delta),
    .t_val   (t_val),
    .t_low   (t_low4),
    .tag     (tag4),
    .y_out   (y_out)
  );

  // input is refused only when every stage holds a word
  `TANHQ_ASSERT_NOW(a_full_when_blocked, clk, rst, !s_axis_tready, &v, "input blocked with a free stage")

  // the output stage holds only when its word waits to be taken
  `TANHQ_ASSERT_NOW(a_hold_only_on_stall, clk, rst, !ld[NUM_STAGES-1], m_axis_tvalid && !m_axis_tready, "output stage held without a stall")

  // words in flight change only by accepted inputs and delivered outputs
  `TANHQ_ASSERT_NEXT(a_word_count, clk, rst, !rst, $countones(v) == $past($countones(v)) + int'($past(in_acc)) - int'($past(out_acc)), "word lost or duplicated in pipe")

endmodule

[sim/tanh_q24_interp_lookup_unit_chk.sv]
// Checker for the tanh lookup unit: watches both stream channels, predicts
// each output word from its own tables and compares. Depends on tanhq_pkg.
`timescale 1ns / 1ps

module tanh_q24_interp_lookup_unit_chk #(
  parameter int EXP2_LOG_ENTRIES = tanhq_pkg::EXP2_LOG_DEF,
  parameter int TANH_LOG_ENTRIES = tanhq_pkg::TANH_LOG_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] x_in
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,   // [25:0] y_out, [31:26] zero
  output int          mismatches,
  output int          in_flight,
  output int          results_seen,
  output int          n_table,
  output int          n_exp2,
  output int          n_sat
);
  import tanhq_pkg::*;

  localparam int EXP2_N  = 1 << EXP2_LOG_ENTRIES;
  localparam int TANH_N  = 1 << TANH_LOG_ENTRIES;
  localparam int EXP2_SH = 24 - EXP2_LOG_ENTRIES;
  localparam int TANH_SH = 26 - TANH_LOG_ENTRIES;
  localparam logic [63:0] Q60_ONE = 64'd1 << 60;

  // (value, slope) tables, rebuilt here from first principles
  logic [31:0] exp2_val  [EXP2_N];
  logic [31:0] exp2_step [EXP2_N];
  int          tanh_val  [TANH_N];
  int          tanh_step [TANH_N];

  logic [25:0] tanh_expected_q [$];

  // floor(sqrt(v * 2^62)), i.e. square root in Q62
  function automatic logic [63:0] sqrt_q62(input logic [63:0] v);
    logic [127:0] target;
    logic [63:0]  root, trial;
    target = {2'b00, v, 62'd0};
    root = '0;
    for (int b = 62; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if ({64'd0, trial} * {64'd0, trial} <= target) root = trial;
    end
    return root;
  endfunction

  // 1 - y^2 in Q60, y clipped at one
  function automatic logic [63:0] tanh_slope_q60(input logic [63:0] v);
    logic [127:0] sq;
    logic [63:0]  vc;
    vc = (v > Q60_ONE) ? Q60_ONE : v;
    sq = {64'd0, vc} * {64'd0, vc};
    return Q60_ONE - sq[123:60];
  endfunction

  function automatic void build_tables();
    logic [63:0]  ratio, acc, k1, k2, k3, k4, ksum, rounded;
    logic [127:0] prod;
    int           lh, lf;
    lh = TANH_LOG_ENTRIES - 1;
    lf = TANH_LOG_ENTRIES - 2;

    // 2^(1/N) by repeated square roots of 2.0, then geometric walk in Q62
    ratio = 64'h8000_0000_0000_0000;
    for (int i = 0; i < EXP2_LOG_ENTRIES; i++) ratio = sqrt_q62(ratio);
    acc = 64'h4000_0000_0000_0000;
    for (int i = 0; i < EXP2_N; i++) begin
      rounded = acc + (64'd1 << 31);
      exp2_val[i] = rounded[63:32];
      prod = {64'd0, acc} * {64'd0, ratio};
      acc = prod[125:62];
    end
    for (int i = 0; i + 1 < EXP2_N; i++) exp2_step[i] = exp2_val[i+1] - exp2_val[i];
    exp2_step[EXP2_N-1] = 32'h8000_0000 - exp2_val[EXP2_N-1];

    // RK4 on y' = 1 - y^2 over [0,4), Q60
    acc = '0;
    for (int i = 0; i < TANH_N; i++) begin
      rounded = acc + (64'd1 << 35);
      tanh_val[i] = int'(rounded >> 36);
      k1 = tanh_slope_q60(acc);
      k2 = tanh_slope_q60(acc + (k1 >> lh));
      k3 = tanh_slope_q60(acc + (k2 >> lh));
      k4 = tanh_slope_q60(acc + (k3 >> lf));
      ksum = k1 + k4 + 2 * (k2 + k3);
      acc = acc + ((ksum / 6) >> lf);
    end
    for (int i = 0; i + 1 < TANH_N; i++) tanh_step[i] = tanh_val[i+1] - tanh_val[i];
    rounded = acc + (64'd1 << 35);
    tanh_step[TANH_N-1] = int'(rounded >> 36) - tanh_val[TANH_N-1];
  endfunction

  // 2^(sx / 2^24) in Q24 for a negative Q24 exponent
  function automatic logic [31:0] exp2_q24(input logic signed [31:0] sx);
    logic [31:0] u, frac, yv;
    logic [63:0] prod;
    int          idx, shift;
    u = sx;
    frac = u & ((32'd1 << EXP2_SH) - 1);
    idx = int'((u >> EXP2_SH) & (EXP2_N - 1));
    prod = ({32'd0, exp2_step[idx]} * {32'd0, frac}) >> EXP2_SH;
    yv = exp2_val[idx] + prod[31:0];
    shift = 6 - int'(sx >>> 24);
    if (shift < 0) shift = 0;
    if (shift > 31) return '0;
    return yv >> shift;
  endfunction

  function automatic logic [25:0] predict_tanh_q24(input logic [31:0] x, output cls_t cls);
    logic [31:0]        fold, mag, r;
    logic [63:0]        p;
    logic signed [31:0] sx;
    logic [31:0]        frac;
    longint             prod, q;
    int                 idx;
    fold = {32{x[31]}};
    mag = x ^ fold;
    if (mag >= SAT_LIMIT) begin
      cls = CLS_SAT;
      r = 32'(ONE_Q24);
    end else if (mag >= EXP_LIMIT) begin
      cls = CLS_EXP;
      p = 64'(TWO_LOG2E_Q24) * 64'(mag);
      sx = -int'((p + 64'h00FF_FFFF) >> 24);
      r = 32'(ONE_Q24) - (exp2_q24(sx) << 1);
    end else begin
      // table interpolation, product floored
      cls = CLS_TANH;
      frac = mag & ((32'd1 << TANH_SH) - 1);
      idx = int'((mag >> TANH_SH) & (TANH_N - 1));
      prod = longint'(tanh_step[idx]) * longint'(frac);
      q = prod >>> TANH_SH;
      r = 32'(longint'(tanh_val[idx]) + q);
    end
    r = r ^ fold;
    return r[25:0];
  endfunction

  initial build_tables();

  initial begin
    mismatches = 0;
    results_seen = 0;
    n_table = 0;
    n_exp2 = 0;
    n_sat = 0;
  end

  // output side first, so a word cannot meet the expectation pushed this edge
  always @(posedge clk) begin : track
    logic [25:0] want;
    cls_t        cls;
    if (rst) begin
      tanh_expected_q.delete();
      in_flight <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (tanh_expected_q.size() == 0) begin
          $error("unexpected output word %h", m_axis_tdata);
          mismatches++;
        end else begin
          want = tanh_expected_q.pop_front();
          if (m_axis_tdata[25:0] !== want) begin
            $error("y_out: expected %h, actual %h", want, m_axis_tdata[25:0]);
            mismatches++;
          end
          if (m_axis_tdata[31:26] !== 6'd0) begin
            $error("pad: expected %h, actual %h", 6'd0, m_axis_tdata[31:26]);
            mismatches++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = predict_tanh_q24(s_axis_tdata, cls);
        tanh_expected_q.push_back(want);
        case (cls)
          CLS_TANH: n_table++;
          CLS_EXP:  n_exp2++;
          default:  n_sat++;
        endcase
      end
      in_flight <= tanh_expected_q.size();
    end
  end

endmodule

[sim/tanh_q24_interp_lookup_unit_tb.sv]
// Testbench top for the tanh lookup unit: clock, reset, sample stimulus,
// random output stalls and the verdict. Depends on tanhq_pkg and the checker.
`timescale 1ns / 1ps

module tanh_q24_interp_lookup_unit_tb;
  import tanhq_pkg::*;

  localparam int RANDOM_WORDS   = 1350;
  localparam int N_CORNERS      = 23;
  localparam int TIMEOUT_CYCLES = 200000;
  localparam int DRAIN_CYCLES   = NUM_STAGES + 8;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        quiet;         // no idling on either side while set
  int          cycle_count;
  int          mismatches, in_flight, results_seen, n_table, n_exp2, n_sat;

  tanh_q24_interp_lookup_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  tanh_q24_interp_lookup_unit_chk chk (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .mismatches    (mismatches),
    .in_flight     (in_flight),
    .results_seen  (results_seen),
    .n_table       (n_table),
    .n_exp2        (n_exp2),
    .n_sat         (n_sat)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < TIMEOUT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d words outstanding", cycle_count, in_flight);
    $display("FAILURE");
    $finish;
  end

  // downstream stalls about 14% of cycles
  always @(posedge clk) begin
    m_axis_tready <= quiet || ($urandom_range(99) >= 14);
  end

  // range edges, fold cases and table boundaries
  function automatic logic [31:0] corner_sample(input int i);
    case (i)
      0:  return 32'h0000_0000;
      1:  return 32'hFFFF_FFFF;        // folds to zero, negative side
      2:  return 32'h0000_0001;
      3:  return 32'h0000_FFFF;        // all interpolation bits, first entry
      4:  return 32'h0001_0000;
      5:  return 32'h0100_0000;        // 1.0
      6:  return 32'hFF00_0000;        // -1.0
      7:  return EXP_LIMIT - 1;        // top of the table range
      8:  return ~(EXP_LIMIT - 1);
      9:  return EXP_LIMIT;            // first exp2 sample
      10: return ~EXP_LIMIT;
      11: return SAT_LIMIT - 1;        // largest exp2 shift
      12: return ~(SAT_LIMIT - 1);
      13: return SAT_LIMIT;            // first saturated sample
      14: return ~SAT_LIMIT;
      15: return 32'h7FFF_FFFF;
      16: return 32'h8000_0000;        // most negative, folds to max
      17: return 32'h0600_0000;
      18: return 32'h0500_0000;
      19: return 32'hAAAA_AAAA;
      20: return 32'h5555_5555;
      21: return 32'h03FF_0000;        // last table entry
      default: return 32'h0200_8000;
    endcase
  endfunction

  // mostly in-range magnitudes, sign applied by ones complement
  function automatic logic [31:0] pick_sample();
    logic [31:0] mag;
    int          kind;
    kind = $urandom_range(99);
    if (kind < 40) mag = $urandom_range(EXP_LIMIT - 1, 0);
    else if (kind < 70) mag = $urandom_range(SAT_LIMIT - 1, EXP_LIMIT);
    else if (kind < 85) mag = $urandom_range(32'h7FFF_FFFF, SAT_LIMIT);
    else return $urandom();
    return $urandom_range(1) ? ~mag : mag;
  endfunction

  // offer one word and hold it until taken
  task automatic send_sample(input logic [31:0] x);
    if (!quiet && $urandom_range(99) < 14) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= x;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // stop sending until every outstanding word has come back
  task automatic wait_for_empty();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
  endtask

  initial begin
    rst           = 1'b1;
    quiet         = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_CORNERS; i++) send_sample(corner_sample(i));
    wait_for_empty();

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == 500) quiet <= 1'b1;
      if (i == 800) quiet <= 1'b0;
      if (i == 1000) wait_for_empty();
      send_sample(pick_sample());
    end

    wait_for_empty();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d samples: %0d table, %0d exp2, %0d saturated; %0d words compared",
             n_table + n_exp2 + n_sat, n_table, n_exp2, n_sat, results_seen);
    $display("Corners, random signs, idle and stall gaps, one stall-free stretch; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
